@@ sv/console_line_editor_tokenizer_defines.svh @@
// ----------------------------------------------------------------------------
// console_line_editor_tokenizer_defines
// Assertion macros used by the checker file of the line editor.
// ----------------------------------------------------------------------------
`ifndef CONSOLE_LINE_EDITOR_TOKENIZER_DEFINES_SVH
`define CONSOLE_LINE_EDITOR_TOKENIZER_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define CLE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define CLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/cle_pkg.sv @@
// ----------------------------------------------------------------------------
// cle_pkg
// Types, character codes and command/status bundles of the line editor.
// ----------------------------------------------------------------------------
package cle_pkg;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_PROMPT = 8'h3E;

  localparam logic [1:0] KIND_ECHO = 2'd0;
  localparam logic [1:0] KIND_ARG  = 2'd1;
  localparam logic [1:0] KIND_LINE = 2'd2;

  localparam logic [2:0] ERASE_LAST = 3'd6;

  typedef enum logic [2:0] {
    DP_NONE,
    DP_STORE,
    DP_BACK,
    DP_ECHO,
    DP_START,
    DP_SCAN,
    DP_REC
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [7:0] ch;
    logic       last;
  } dp_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic cur_zero;
    logic cur_full;
    logic scan_done;
  } dp_sts_t;

  // erase sequence: ESC [ D space ESC [ D
  function automatic logic [7:0] erase_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0, 3'd4: b = CH_ESC;
      3'd1, 3'd5: b = 8'h5B;
      3'd2, 3'd6: b = 8'h44;
      3'd3:       b = CH_SPACE;
      default:    b = CH_SPACE;
    endcase
    return b;
  endfunction

endpackage

@@ sv/cle_if.sv @@
// ----------------------------------------------------------------------------
// cle_if
// Valid/ready channels of the line editor: received bytes in, results out.
// ----------------------------------------------------------------------------
interface cle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cle_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic [2:0] arg_number;
  logic       arg_end;
  logic [3:0] arg_count;
  logic       last;

  modport source (output valid, output kind, output data_byte, output arg_number,
                  output arg_end, output arg_count, output last, input ready);
  modport sink   (input valid, input kind, input data_byte, input arg_number,
                  input arg_end, input arg_count, input last, output ready);
endinterface

@@ sv/cle_ctrl.sv @@
// ----------------------------------------------------------------------------
// cle_ctrl
// Sequencer: classifies received bytes and steps echo, scan and prompt phases.
// ----------------------------------------------------------------------------
module cle_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [7:0]        rx_byte_i,
  output logic              in_ready_o,
  input  cle_pkg::dp_sts_t  sts_i,
  output cle_pkg::dp_cmd_t  cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ERASE = 3'd1;
  localparam logic [2:0] ST_LF    = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_REC   = 3'd4;
  localparam logic [2:0] ST_PR0   = 3'd5;
  localparam logic [2:0] ST_PR1   = 3'd6;

  logic [2:0] state_q, state_d;
  logic [2:0] idx_q, idx_d;
  logic       accept;

  assign in_ready_o = (state_q == ST_IDLE) && sts_i.slot_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    cmd_o.op    = cle_pkg::DP_NONE;
    cmd_o.ch    = 8'h00;
    cmd_o.last  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (rx_byte_i) inside
            cle_pkg::CH_CR, cle_pkg::CH_LF: begin
              cmd_o.op = cle_pkg::DP_START;
              cmd_o.ch = cle_pkg::CH_CR;
              state_d  = ST_LF;
            end
            cle_pkg::CH_ESC: begin
            end
            cle_pkg::CH_BS: begin
              if (!sts_i.cur_zero) begin
                cmd_o.op = cle_pkg::DP_BACK;
                cmd_o.ch = cle_pkg::erase_byte(3'd0);
                idx_d    = 3'd1;
                state_d  = ST_ERASE;
              end
            end
            default: begin
              if (!sts_i.cur_full) begin
                cmd_o.op = cle_pkg::DP_STORE;
              end
            end
          endcase
        end
      end
      ST_ERASE: begin
        if (sts_i.slot_free) begin
          cmd_o.op   = cle_pkg::DP_ECHO;
          cmd_o.ch   = cle_pkg::erase_byte(idx_q);
          cmd_o.last = (idx_q == cle_pkg::ERASE_LAST);
          idx_d      = idx_q + 3'd1;
          if (idx_q == cle_pkg::ERASE_LAST) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_LF: begin
        if (sts_i.slot_free) begin
          cmd_o.op = cle_pkg::DP_ECHO;
          cmd_o.ch = cle_pkg::CH_LF;
          state_d  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.op = cle_pkg::DP_SCAN;
        if (sts_i.scan_done) begin
          state_d = ST_REC;
        end
      end
      ST_REC: begin
        if (sts_i.slot_free) begin
          cmd_o.op = cle_pkg::DP_REC;
          state_d  = ST_PR0;
        end
      end
      ST_PR0: begin
        if (sts_i.slot_free) begin
          cmd_o.op = cle_pkg::DP_ECHO;
          cmd_o.ch = cle_pkg::CH_PROMPT;
          state_d  = ST_PR1;
        end
      end
      ST_PR1: begin
        if (sts_i.slot_free) begin
          cmd_o.op   = cle_pkg::DP_ECHO;
          cmd_o.ch   = cle_pkg::CH_SPACE;
          cmd_o.last = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= 3'd0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

endmodule

@@ sv/cle_dp.sv @@
// ----------------------------------------------------------------------------
// cle_dp
// Datapath: line memory, cursor, argument scanner and result register.
// ----------------------------------------------------------------------------
module cle_dp #(
  parameter int unsigned LINE_BYTES = 32,
  parameter int unsigned MAX_ARGS   = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cle_pkg::dp_cmd_t  cmd_i,
  input  logic [7:0]        rx_byte_i,
  output cle_pkg::dp_sts_t  sts_o,
  cle_out_if.source         out_o
);

  localparam int unsigned CW    = $clog2(LINE_BYTES);
  localparam int unsigned CNT_W = $clog2(MAX_ARGS + 1);

  logic [7:0]       mem_q [LINE_BYTES];
  logic [7:0]       rd_data_q;
  logic [CW-1:0]    cursor_q, cursor_d;
  logic [CW-1:0]    pos_q, pos_d;
  logic             pend_v_q, pend_v_d;
  logic [7:0]       pend_c_q, pend_c_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] cnt_inc;
  logic [31:0]      cnt_ext;

  logic             out_valid_q;
  logic [1:0]       kind_q, kind_d;
  logic [7:0]       data_q, data_d;
  logic [2:0]       num_q, num_d;
  logic             end_q, end_d;
  logic [3:0]       count_q, count_d;
  logic             last_q, last_d;

  logic             emit, wr_en, slot_free, at_end, sep, cnt_hit;
  logic [7:0]       wr_data;

  assign slot_free = !out_valid_q || out_o.ready;
  assign at_end    = (pos_q == cursor_q);
  assign sep       = (rd_data_q == 8'h00);
  assign cnt_inc   = cnt_q + CNT_W'(1);
  assign cnt_hit   = (cnt_inc == CNT_W'(MAX_ARGS));
  assign cnt_ext   = 32'(cnt_q);
  assign wr_data   = ((rx_byte_i == cle_pkg::CH_TAB) || (rx_byte_i == cle_pkg::CH_SPACE))
                     ? 8'h00 : rx_byte_i;

  assign sts_o.slot_free = slot_free;
  assign sts_o.cur_zero  = (cursor_q == '0);
  assign sts_o.cur_full  = (cursor_q == CW'(LINE_BYTES - 1));
  assign sts_o.scan_done = at_end ? (!pend_v_q || slot_free)
                                  : (pend_v_q && sep && slot_free && cnt_hit);

  always_comb begin
    emit     = 1'b0;
    wr_en    = 1'b0;
    cursor_d = cursor_q;
    pos_d    = pos_q;
    pend_v_d = pend_v_q;
    pend_c_d = pend_c_q;
    cnt_d    = cnt_q;
    kind_d   = cle_pkg::KIND_ECHO;
    data_d   = cmd_i.ch;
    num_d    = 3'd0;
    end_d    = 1'b0;
    count_d  = 4'd0;
    last_d   = cmd_i.last;
    unique case (cmd_i.op)
      cle_pkg::DP_NONE: begin
      end
      cle_pkg::DP_STORE: begin
        emit     = 1'b1;
        data_d   = rx_byte_i;
        last_d   = 1'b1;
        wr_en    = 1'b1;
        cursor_d = cursor_q + CW'(1);
      end
      cle_pkg::DP_BACK: begin
        emit     = 1'b1;
        cursor_d = cursor_q - CW'(1);
      end
      cle_pkg::DP_ECHO: begin
        emit = 1'b1;
      end
      cle_pkg::DP_START: begin
        emit     = 1'b1;
        pos_d    = '0;
        pend_v_d = 1'b0;
        cnt_d    = '0;
      end
      cle_pkg::DP_SCAN: begin
        kind_d = cle_pkg::KIND_ARG;
        data_d = pend_c_q;
        num_d  = cnt_ext[2:0];
        last_d = 1'b0;
        if (at_end) begin
          if (pend_v_q && slot_free) begin
            emit     = 1'b1;
            end_d    = 1'b1;
            cnt_d    = cnt_inc;
            pend_v_d = 1'b0;
          end
        end else if (pend_v_q) begin
          if (slot_free) begin
            emit  = 1'b1;
            end_d = sep;
            pos_d = pos_q + CW'(1);
            if (sep) begin
              pend_v_d = 1'b0;
              cnt_d    = cnt_inc;
            end else begin
              pend_c_d = rd_data_q;
            end
          end
        end else begin
          pos_d = pos_q + CW'(1);
          if (!sep) begin
            pend_v_d = 1'b1;
            pend_c_d = rd_data_q;
          end
        end
      end
      cle_pkg::DP_REC: begin
        emit     = 1'b1;
        kind_d   = cle_pkg::KIND_LINE;
        data_d   = 8'h00;
        count_d  = cnt_ext[3:0];
        last_d   = 1'b0;
        cursor_d = '0;
      end
      default: begin
      end
    endcase
  end

  // line memory: one write port, one registered read port following the scan
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[cursor_q] <= wr_data;
    end
    rd_data_q <= mem_q[pos_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q    <= '0;
      pos_q       <= '0;
      pend_v_q    <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cursor_q <= cursor_d;
      pos_q    <= pos_d;
      pend_v_q <= pend_v_d;
      cnt_q    <= cnt_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_c_q <= pend_c_d;
    if (emit) begin
      kind_q  <= kind_d;
      data_q  <= data_d;
      num_q   <= num_d;
      end_q   <= end_d;
      count_q <= count_d;
      last_q  <= last_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.kind       = kind_q;
  assign out_o.data_byte  = data_q;
  assign out_o.arg_number = num_q;
  assign out_o.arg_end    = end_q;
  assign out_o.arg_count  = count_q;
  assign out_o.last       = last_q;

endmodule

@@ sv/console_line_editor_tokenizer.sv @@
// The first result of a byte is in the output register in the cycle after the beat.
// A new byte is taken only while idle with a free output slot; a backspace sends
//   a seven-byte erase sequence, and the line-end scan does one line-memory read
//   per cycle while its output is not stalled.
// Reset: cursor and counters cleared, no prompt sent, line memory not cleared.
// ----------------------------------------------------------------------------
// console_line_editor_tokenizer
// Console line editor: echo, backspace erase and argument splitting at line end.
// ----------------------------------------------------------------------------
module console_line_editor_tokenizer #(
  parameter int unsigned LINE_BYTES = 32,
  parameter int unsigned MAX_ARGS   = 8
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  cle_in_if.sink   in_i,
  cle_out_if.source out_o
);

  cle_pkg::dp_cmd_t cmd;
  cle_pkg::dp_sts_t sts;
  logic             in_ready;

  assign in_i.ready = in_ready;

  cle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .rx_byte_i  (in_i.rx_byte),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cle_dp #(
    .LINE_BYTES (LINE_BYTES),
    .MAX_ARGS   (MAX_ARGS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .rx_byte_i (in_i.rx_byte),
    .sts_o     (sts),
    .out_o     (out_o)
  );

endmodule

@@ sv/cle_checker.sv @@
// ----------------------------------------------------------------------------
// cle_checker
// Port-level checks of the line editor, bound to the top level.
// ----------------------------------------------------------------------------
`include "console_line_editor_tokenizer_defines.svh"

module cle_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic [7:0] rx_byte_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] kind_i,
  input logic [7:0] data_byte_i,
  input logic [2:0] arg_number_i,
  input logic [3:0] arg_count_i,
  input logic       last_i
);

  `CLE_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i,
    out_valid_i && $stable(data_byte_i) && $stable(kind_i) && $stable(last_i),
    "stalled beat changed")
  `CLE_ASSERT_NOW(a_no_take_when_full, out_valid_i && !out_ready_i, !in_ready_i,
    "input taken while result stalled")
  `CLE_ASSERT_NEXT(a_cr_first, in_valid_i && in_ready_i &&
    (rx_byte_i == cle_pkg::CH_CR || rx_byte_i == cle_pkg::CH_LF),
    out_valid_i && kind_i == cle_pkg::KIND_ECHO && data_byte_i == cle_pkg::CH_CR && !last_i,
    "line end must open with CR echo")
  `CLE_ASSERT_NOW(a_rec_shape, out_valid_i && kind_i == cle_pkg::KIND_LINE,
    !last_i && data_byte_i == 8'h00 && arg_number_i == 3'd0, "bad line record")
  `CLE_ASSERT_NOW(a_echo_count, out_valid_i && kind_i == cle_pkg::KIND_ECHO,
    arg_count_i == 4'd0 && arg_number_i == 3'd0, "echo beat carries counts")

endmodule

bind console_line_editor_tokenizer cle_checker u_cle_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .rx_byte_i    (in_i.rx_byte),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .kind_i       (out_o.kind),
  .data_byte_i  (out_o.data_byte),
  .arg_number_i (out_o.arg_number),
  .arg_count_i  (out_o.arg_count),
  .last_i       (out_o.last)
);

@@ verif/cle_echo_arg_check.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cle_echo_arg_check
// Watches the byte and result channels of the console line editor, keeps its
// own line buffer and cursor, and checks every result beat in order against
// the echo, argument and line records expected from the received bytes.
// ----------------------------------------------------------------------------
module cle_echo_arg_check #(
  parameter int unsigned LINE_BYTES = 32,
  parameter int unsigned MAX_ARGS   = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  cle_in_if    in_ch,
  cle_out_if   out_ch,
  output int   fail_count_o,
  output int   pending_o
);

  localparam int unsigned IW = $clog2(LINE_BYTES);
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_CAP_D    = 8'h44;
  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] ERASE_SEQ [7] = '{cle_pkg::CH_ESC, CH_LBRACKET, CH_CAP_D,
                                           cle_pkg::CH_SPACE, cle_pkg::CH_ESC,
                                           CH_LBRACKET, CH_CAP_D};

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [2:0] arg_number;
    logic       arg_end;
    logic [3:0] arg_count;
    logic       last;
  } cle_result_t;

  cle_result_t expected_q[$];
  logic [7:0]  line_buf [LINE_BYTES];
  int unsigned cursor;
  int          errors;

  function automatic void push_result(logic [1:0] kind, logic [7:0] data,
                                      int unsigned argn, logic aend, int unsigned cnt);
    cle_result_t r;
    r.kind       = kind;
    r.data_byte  = data;
    r.arg_number = argn[2:0];
    r.arg_end    = aend;
    r.arg_count  = cnt[3:0];
    r.last       = 1'b0;
    expected_q.push_back(r);
  endfunction

  // line end: CR LF, argument bytes, line record, prompt
  function automatic void split_line();
    int unsigned lim;
    int unsigned idx;
    int unsigned count;
    logic        endc;
    lim   = cursor;
    idx   = 0;
    count = 0;
    push_result(cle_pkg::KIND_ECHO, cle_pkg::CH_CR, 0, 1'b0, 0);
    push_result(cle_pkg::KIND_ECHO, cle_pkg::CH_LF, 0, 1'b0, 0);
    while (count < MAX_ARGS) begin
      while (idx < lim && line_buf[IW'(idx)] == CH_NUL) idx++;
      if (idx >= lim) break;
      while (idx < lim && line_buf[IW'(idx)] != CH_NUL) begin
        endc = (idx + 1 >= lim) || (line_buf[IW'(idx + 1)] == CH_NUL);
        push_result(cle_pkg::KIND_ARG, line_buf[IW'(idx)], count, endc, 0);
        idx++;
      end
      count++;
    end
    push_result(cle_pkg::KIND_LINE, CH_NUL, 0, 1'b0, count);
    cursor = 0;
    push_result(cle_pkg::KIND_ECHO, cle_pkg::CH_PROMPT, 0, 1'b0, 0);
    push_result(cle_pkg::KIND_ECHO, cle_pkg::CH_SPACE, 0, 1'b0, 0);
  endfunction

  function automatic void edit_line_byte(logic [7:0] ch);
    int unsigned before_n;
    cle_result_t r;
    before_n = expected_q.size();
    if (ch == cle_pkg::CH_CR || ch == cle_pkg::CH_LF) begin
      split_line();
    end else if (ch == cle_pkg::CH_ESC) begin
    end else if (ch == cle_pkg::CH_BS) begin
      if (cursor > 0) begin
        foreach (ERASE_SEQ[i]) push_result(cle_pkg::KIND_ECHO, ERASE_SEQ[i], 0, 1'b0, 0);
        cursor--;
      end
    end else if (cursor < LINE_BYTES - 1) begin
      push_result(cle_pkg::KIND_ECHO, ch, 0, 1'b0, 0);
      line_buf[IW'(cursor)] = (ch == cle_pkg::CH_TAB || ch == cle_pkg::CH_SPACE)
                              ? CH_NUL : ch;
      cursor++;
    end
    if (expected_q.size() > before_n) begin
      r = expected_q.pop_back();
      r.last = 1'b1;
      expected_q.push_back(r);
    end
  endfunction

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cle_result_t want;
    if (!rst_ni) begin
      expected_q.delete();
      cursor       = 0;
      errors       = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) edit_line_byte(in_ch.rx_byte);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected beat: kind %0d data_byte %0d", out_ch.kind, out_ch.data_byte);
          errors++;
        end else begin
          want = expected_q.pop_front();
          check_field("kind", 32'(want.kind), 32'(out_ch.kind));
          check_field("data_byte", 32'(want.data_byte), 32'(out_ch.data_byte));
          check_field("arg_number", 32'(want.arg_number), 32'(out_ch.arg_number));
          check_field("arg_end", 32'(want.arg_end), 32'(out_ch.arg_end));
          check_field("arg_count", 32'(want.arg_count), 32'(out_ch.arg_count));
          check_field("last", 32'(want.last), 32'(out_ch.last));
        end
      end
      fail_count_o <= errors;
      pending_o    <= expected_q.size();
    end
  end

endmodule

@@ verif/console_line_editor_tokenizer_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// console_line_editor_tokenizer_tb
// Feeds the line editor a short directed set of console bytes, then random
// lines (short, overfull, many-argument) mixed with raw noise bytes, with
// random idling on both channels; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module console_line_editor_tokenizer_tb;

  localparam int unsigned LINE_BYTES = 32;
  localparam int unsigned MAX_ARGS   = 8;
  localparam int unsigned N_ITEMS    = 460;
  localparam logic [7:0] DIRECTED [20] = '{
    cle_pkg::CH_CR, cle_pkg::CH_BS, cle_pkg::CH_ESC, 8'h61, 8'h00, 8'hFF, 8'h7F,
    cle_pkg::CH_SPACE, cle_pkg::CH_TAB, 8'h62, cle_pkg::CH_BS, 8'h63, 8'h64,
    cle_pkg::CH_LF, 8'h78, cle_pkg::CH_SPACE, cle_pkg::CH_SPACE, 8'h79,
    cle_pkg::CH_TAB, cle_pkg::CH_CR};

  logic clk_i;
  logic rst_ni;
  logic steady;
  int   fail_count;
  int   pending;
  int   sent;

  cle_in_if  in_ch ();
  cle_out_if out_ch ();

  console_line_editor_tokenizer #(
    .LINE_BYTES(LINE_BYTES),
    .MAX_ARGS  (MAX_ARGS)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  cle_echo_arg_check #(
    .LINE_BYTES(LINE_BYTES),
    .MAX_ARGS  (MAX_ARGS)
  ) u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= steady || ($urandom_range(0, 99) >= 26);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while (!steady && $urandom_range(0, 99) < 26) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sent++;
  endtask

  function automatic logic [7:0] pick_line_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 62) return 8'($urandom_range(8'h21, 8'h7E));
    if (r < 74) return cle_pkg::CH_SPACE;
    if (r < 80) return cle_pkg::CH_TAB;
    if (r < 88) return cle_pkg::CH_BS;
    if (r < 91) return cle_pkg::CH_ESC;
    if (r < 94) return 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  // short lines, lines that overrun the buffer, and lines with many arguments
  task automatic send_line();
    int unsigned shape;
    int unsigned len;
    shape = $urandom_range(0, 9);
    if (shape < 6) len = $urandom_range(0, 12);
    else if (shape < 8) len = $urandom_range(25, 40);
    else len = $urandom_range(16, 30);
    for (int unsigned i = 0; i < len; i++) begin
      if (shape >= 8) begin
        if (i % 2 == 1) send_byte($urandom_range(0, 1) ? cle_pkg::CH_SPACE : cle_pkg::CH_TAB);
        else send_byte(8'($urandom_range(8'h21, 8'h7E)));
      end else begin
        send_byte(pick_line_byte());
      end
    end
    send_byte($urandom_range(0, 1) ? cle_pkg::CH_CR : cle_pkg::CH_LF);
  endtask

  initial begin
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= 8'h00;
    steady        = 1'b0;
    sent          = 0;
    rst_ni        <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[i]) send_byte(DIRECTED[i]);

    while (sent < N_ITEMS) begin
      steady = (sent >= 200 && sent < 300);
      if ($urandom_range(0, 99) < 80) begin
        send_line();
      end else begin
        repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
      end
    end
    steady = 1'b0;
    in_ch.valid <= 1'b0;

    do @(posedge clk_i); while (pending != 0);
    repeat (100) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
